// ===== rtl/modbus_rtu_slave_frame_handler_core_assert.svh =====
// assertion macros shared by the frame handler rtl
`ifndef MODBUS_RTU_SLAVE_FRAME_HANDLER_CORE_ASSERT_SVH
`define MODBUS_RTU_SLAVE_FRAME_HANDLER_CORE_ASSERT_SVH
`ifndef SYNTH
`define MRTU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define MRTU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define MRTU_ASSERT(label, prop, msg)
`define MRTU_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/mrtu_pkg.sv =====
// types, constants and crc helper for the modbus rtu frame handler
package mrtu_pkg;

    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [7:0]  FUNC_READ     = 8'h03;
    localparam logic [7:0]  FUNC_WRITE    = 8'h06;
    localparam logic [7:0]  EXC_FLAG      = 8'h80;
    localparam logic [7:0]  EXC_BAD_ADDR  = 8'h02;
    localparam logic [7:0]  EXC_BAD_VALUE = 8'h03;
    localparam logic [7:0]  READ_BYTES    = 8'h02;
    localparam logic [7:0]  BROADCAST     = 8'hFF;
    localparam logic [7:0]  SHORT_HEAD    = 8'hFF;
    localparam logic [15:0] STATION_MAX   = 16'd247;
    localparam logic [15:0] BAUD_MAX      = 16'd9;
    localparam logic [15:0] DIST_MIN      = 16'd50;
    localparam logic [15:0] DIST_MAX      = 16'd2000;
    localparam logic [3:0]  SHORT_LEN     = 4'd4;

    localparam int IN_BITS   = 81;
    localparam int OUT_BITS  = 73;
    localparam int IN_BYTES  = 11;
    localparam int OUT_BYTES = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_MODE   = 3'd0,
        CFG_ADDR_SAVED   = 3'd1,
        CFG_ADDR_LIVE    = 3'd2,
        CFG_ADDR_BAUD    = 3'd3,
        CFG_ADDR_STATION = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic        measure_ok;
        logic [15:0] measured_distance;
        logic [15:0] crc_word;
        logic [15:0] reg_value;
        logic [15:0] target_reg;
        logic [7:0]  func;
        logic [7:0]  station;
    } req_t;

    typedef struct packed {
        logic        baud_update;
        logic [3:0]  baud_select;
        logic [3:0]  resp_len;
        logic [63:0] resp_bytes;
    } resp_t;

    typedef struct packed {
        logic        short_mode;
        logic [15:0] addr_saved;
        logic [15:0] addr_live;
        logic [15:0] addr_baud;
        logic [15:0] addr_station;
    } cfg_t;

    typedef struct packed {
        logic        resp_valid;
        logic        held_we;
        logic [15:0] held_value;
        logic        station_we;
        logic [7:0]  station_value;
    } upd_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/modbus_rtu_slave_frame_handler_core.sv =====
// modbus rtu slave frame handler: input register, decode pass, result register
// One whole 8-byte request with its distance measurement enters per transaction, and the
// block takes a new one every cycle while the result side keeps up; the response is offered
// once the request has passed from the input register through the single combinational
// pass (request crc check, decode, response crc) into the result register. Requests for
// another station, with a bad crc, or with an unhandled function or write address give
// no response. Station address and held distance are updated in the same pass, so the
// next request already sees them. Configuration writes must only be made while no request
// is in flight.
module modbus_rtu_slave_frame_handler_core #(
    parameter int DEFAULT_STATION = 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // station, func, target_reg, reg_value, crc_word, measured_distance, measure_ok, zero pad
    input  logic [mrtu_pkg::IN_BYTES*8-1:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // resp_bytes, resp_len, baud_select, baud_update, zero pad
    output logic [mrtu_pkg::OUT_BYTES*8-1:0] m_tdata,
    input  logic        cfg_we,
    input  logic [mrtu_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [mrtu_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam logic [7:0] DefStation = 8'(DEFAULT_STATION);

    logic            in_valid_reg;
    mrtu_pkg::req_t  in_reg;
    logic            out_valid_reg;
    mrtu_pkg::resp_t out_reg;
    logic [7:0]      station_reg;
    logic [15:0]     held_reg;
    mrtu_pkg::cfg_t  cfg_reg;
    mrtu_pkg::resp_t resp_next;
    mrtu_pkg::upd_t  upd;
    logic            adv;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mrtu_pkg::OUT_BYTES*8-mrtu_pkg::OUT_BITS){1'b0}}, out_reg};

    mrtu_resp u_resp (
        .req           (in_reg),
        .cfg           (cfg_reg),
        .station_addr  (station_reg),
        .held_distance (held_reg),
        .resp          (resp_next),
        .upd           (upd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready) begin
            in_reg <= mrtu_pkg::req_t'(s_tdata[mrtu_pkg::IN_BITS-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            station_reg   <= DefStation;
            held_reg      <= 16'd0;
        end else if (adv) begin
            out_valid_reg <= in_valid_reg && upd.resp_valid;
            if (in_valid_reg && upd.station_we) begin
                station_reg <= upd.station_value;
            end
            if (in_valid_reg && upd.held_we) begin
                held_reg <= upd.held_value;
            end
        end
        if (adv) begin
            out_reg <= resp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_mode   <= 1'b0;
            cfg_reg.addr_saved   <= 16'd256;
            cfg_reg.addr_live    <= 16'd257;
            cfg_reg.addr_baud    <= 16'd512;
            cfg_reg.addr_station <= 16'd513;
        end else if (cfg_we) begin
            case (cfg_addr)
                mrtu_pkg::CFG_SHORT_MODE:   cfg_reg.short_mode   <= cfg_wdata[0];
                mrtu_pkg::CFG_ADDR_SAVED:   cfg_reg.addr_saved   <= cfg_wdata;
                mrtu_pkg::CFG_ADDR_LIVE:    cfg_reg.addr_live    <= cfg_wdata;
                mrtu_pkg::CFG_ADDR_BAUD:    cfg_reg.addr_baud    <= cfg_wdata;
                mrtu_pkg::CFG_ADDR_STATION: cfg_reg.addr_station <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

`include "modbus_rtu_slave_frame_handler_core_assert.svh"

    `MRTU_ASSERT(a_resp_len, m_tvalid |-> (out_reg.resp_len == 4'd4 || out_reg.resp_len == 4'd5 || out_reg.resp_len == 4'd7 || out_reg.resp_len == 4'd8), "bad response length")
    `MRTU_ASSERT(a_baud_ack, (m_tvalid && out_reg.baud_update) |-> (out_reg.resp_len == 4'd8), "baud change not in a write echo")
    `MRTU_ASSERT(a_station_range, (station_reg != 8'd0) && (station_reg <= 8'd247), "station address out of range")
    `MRTU_ASSERT_ALWAYS(a_held_update, (aresetn && $past(aresetn) && !$stable(held_reg)) |-> $past(adv && in_valid_reg), "held distance changed without a request")

endmodule

// ===== rtl/mrtu_crc16.sv =====
// crc-16 over the first nbytes of a six byte field
module mrtu_crc16 (
    input  logic [5:0][7:0] data,
    input  logic [2:0]      nbytes,
    output logic [15:0]     crc
);

    always_comb begin
        logic [15:0] acc;
        logic [15:0] step;
        acc = mrtu_pkg::CRC_INIT;
        for (int i = 0; i < 6; i++) begin
            step = mrtu_pkg::crc16_byte(acc, data[i]);
            if (3'(i) < nbytes) begin
                acc = step;
            end
        end
        crc = acc;
    end

endmodule

// ===== rtl/mrtu_resp.sv =====
// request check, command decode and response frame assembly
module mrtu_resp (
    input  mrtu_pkg::req_t  req,
    input  mrtu_pkg::cfg_t  cfg,
    input  logic [7:0]      station_addr,
    input  logic [15:0]     held_distance,
    output mrtu_pkg::resp_t resp,
    output mrtu_pkg::upd_t  upd
);

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_EXC,
        KIND_READ,
        KIND_ACK,
        KIND_SHORT
    } kind_t;

    logic [5:0][7:0] req_data;
    logic [15:0]     req_crc;
    logic            addr_ok;
    logic            crc_ok;
    kind_t           kind;
    logic [7:0]      exc_code;
    logic [15:0]     read_val;
    logic [15:0]     short_val;
    logic [15:0]     clamp_val;
    logic [7:0]      short_sum;
    logic [5:0][7:0] pre;
    logic [2:0]      pre_len;
    logic [15:0]     resp_crc;
    logic            value_ok;
    logic            baud_upd;
    logic [3:0]      baud_sel;

    assign req_data = {req.reg_value[7:0], req.reg_value[15:8],
                       req.target_reg[7:0], req.target_reg[15:8],
                       req.func, req.station};

    mrtu_crc16 u_req_crc (
        .data   (req_data),
        .nbytes (3'd6),
        .crc    (req_crc)
    );

    assign addr_ok = (req.station == station_addr) || (req.station == mrtu_pkg::BROADCAST);
    assign crc_ok  = (req_crc == req.crc_word);
    assign value_ok = (req.reg_value != 16'd0) && (req.reg_value <= mrtu_pkg::STATION_MAX);

    always_comb begin
        kind                = KIND_NONE;
        exc_code            = mrtu_pkg::EXC_BAD_VALUE;
        read_val            = req.measured_distance;
        short_val           = held_distance;
        upd.held_we         = 1'b0;
        upd.held_value      = req.measured_distance;
        upd.station_we      = 1'b0;
        upd.station_value   = req.reg_value[7:0];
        baud_upd            = 1'b0;
        baud_sel            = 4'd0;
        case (req.func)
            mrtu_pkg::FUNC_READ: begin
                if (req.reg_value != 16'd1) begin
                    kind = KIND_EXC;
                end else if (req.target_reg == cfg.addr_saved) begin
                    kind = cfg.short_mode ? KIND_SHORT : KIND_READ;
                end else if (req.target_reg == cfg.addr_live) begin
                    if (req.measure_ok) begin
                        upd.held_we = 1'b1;
                        short_val   = req.measured_distance;
                        kind        = cfg.short_mode ? KIND_SHORT : KIND_READ;
                    end else begin
                        kind = KIND_EXC;
                    end
                end else begin
                    kind     = KIND_EXC;
                    exc_code = mrtu_pkg::EXC_BAD_ADDR;
                end
            end
            mrtu_pkg::FUNC_WRITE: begin
                if (req.target_reg == cfg.addr_baud) begin
                    kind     = KIND_ACK;
                    baud_upd = 1'b1;
                    if (req.reg_value != 16'd0 && req.reg_value <= mrtu_pkg::BAUD_MAX) begin
                        baud_sel = req.reg_value[3:0];
                    end
                end else if (req.target_reg == cfg.addr_station) begin
                    if (value_ok) begin
                        kind           = KIND_ACK;
                        upd.station_we = 1'b1;
                    end else begin
                        kind = KIND_EXC;
                    end
                end
            end
            default: begin
                kind = KIND_NONE;
            end
        endcase
        if (!(addr_ok && crc_ok)) begin
            kind             = KIND_NONE;
            upd.held_we      = 1'b0;
            upd.station_we   = 1'b0;
        end
        upd.resp_valid = (kind != KIND_NONE);
    end

    always_comb begin
        if (short_val <= mrtu_pkg::DIST_MIN) begin
            clamp_val = mrtu_pkg::DIST_MIN;
        end else if (short_val >= mrtu_pkg::DIST_MAX) begin
            clamp_val = mrtu_pkg::DIST_MAX;
        end else begin
            clamp_val = short_val;
        end
        short_sum = mrtu_pkg::SHORT_HEAD + clamp_val[15:8] + clamp_val[7:0];
    end

    always_comb begin
        pre     = '0;
        pre_len = 3'd3;
        case (kind)
            KIND_EXC: begin
                pre[0]  = station_addr;
                pre[1]  = req.func | mrtu_pkg::EXC_FLAG;
                pre[2]  = exc_code;
                pre_len = 3'd3;
            end
            KIND_READ: begin
                pre[0]  = station_addr;
                pre[1]  = mrtu_pkg::FUNC_READ;
                pre[2]  = mrtu_pkg::READ_BYTES;
                pre[3]  = read_val[15:8];
                pre[4]  = read_val[7:0];
                pre_len = 3'd5;
            end
            KIND_ACK: begin
                pre[0]  = station_addr;
                pre[1]  = mrtu_pkg::FUNC_WRITE;
                pre[2]  = req.target_reg[15:8];
                pre[3]  = req.target_reg[7:0];
                pre[4]  = req.reg_value[15:8];
                pre[5]  = req.reg_value[7:0];
                pre_len = 3'd6;
            end
            default: begin
                pre     = '0;
                pre_len = 3'd3;
            end
        endcase
    end

    mrtu_crc16 u_resp_crc (
        .data   (pre),
        .nbytes (pre_len),
        .crc    (resp_crc)
    );

    always_comb begin
        logic [3:0] n;
        n = {1'b0, pre_len};
        resp.baud_update = baud_upd;
        resp.baud_select = baud_sel;
        resp.resp_bytes  = '0;
        resp.resp_len    = n + 4'd2;
        if (kind == KIND_SHORT) begin
            resp.resp_bytes[7:0]   = mrtu_pkg::SHORT_HEAD;
            resp.resp_bytes[15:8]  = clamp_val[15:8];
            resp.resp_bytes[23:16] = clamp_val[7:0];
            resp.resp_bytes[31:24] = short_sum;
            resp.resp_len          = mrtu_pkg::SHORT_LEN;
        end else begin
            for (int i = 0; i < 8; i++) begin
                if (4'(i) < n) begin
                    resp.resp_bytes[8*i +: 8] = pre[i[2:0]];
                end else if (4'(i) == n) begin
                    resp.resp_bytes[8*i +: 8] = resp_crc[7:0];
                end else if (4'(i) == n + 4'd1) begin
                    resp.resp_bytes[8*i +: 8] = resp_crc[15:8];
                end
            end
        end
    end

endmodule

// ===== test/modbus_rtu_slave_frame_handler_core_test.sv =====
// self-checking stream testbench for the modbus rtu slave frame handler core
`timescale 1ns / 100ps

module modbus_rtu_slave_frame_handler_core_test;

    localparam int          STATION_RESET = 1;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          DRAIN_CYCLES  = 8;
    localparam logic [15:0] SAVED_RESET   = 16'd256;
    localparam logic [15:0] LIVE_RESET    = 16'd257;
    localparam logic [15:0] BAUD_RESET    = 16'd512;
    localparam logic [15:0] STN_RESET     = 16'd513;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // station, func, target_reg, reg_value, crc_word, measured_distance, measure_ok, zero pad
    logic [mrtu_pkg::IN_BYTES*8-1:0] s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // resp_bytes, resp_len, baud_select, baud_update, zero pad
    logic [mrtu_pkg::OUT_BYTES*8-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [mrtu_pkg::CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [mrtu_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // mirror of the block state and registers
    bit          cur_short_mode = 1'b0;
    logic [15:0] cur_saved_addr = SAVED_RESET;
    logic [15:0] cur_live_addr = LIVE_RESET;
    logic [15:0] cur_baud_addr = BAUD_RESET;
    logic [15:0] cur_stn_addr = STN_RESET;
    logic [7:0]  station_id = 8'(STATION_RESET);
    logic [15:0] held_dist = '0;

    mrtu_pkg::resp_t expected_responses[$];
    int    error_count = 0;
    int    requests_sent = 0;
    int    responses_seen = 0;
    int    settings_applied = 0;
    int    quiet_cycles = 0;
    bit    src_idling = 1'b0;
    bit    sink_idling = 1'b0;
    bit    sink_hold = 1'b0;

    modbus_rtu_slave_frame_handler_core #(
        .DEFAULT_STATION(STATION_RESET)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #2 aclk = ~aclk;

    function automatic logic [15:0] rand16();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [15:0] modbus_crc(input logic [63:0] bytes, input int n);
        logic [15:0] c;
        c = mrtu_pkg::CRC_INIT;
        for (int i = 0; i < n; i++) begin
            c = c ^ {8'h00, bytes[8*i +: 8]};
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ mrtu_pkg::CRC_POLY) : (c >> 1);
            end
        end
        return c;
    endfunction

    function automatic logic [63:0] sealed(input logic [63:0] f, input int n);
        logic [63:0] g;
        g = f;
        g[8*n +: 16] = modbus_crc(f, n);
        return g;
    endfunction

    function automatic logic [63:0] request_bytes(input mrtu_pkg::req_t r);
        return {16'h0000, r.reg_value[7:0], r.reg_value[15:8],
                r.target_reg[7:0], r.target_reg[15:8], r.func, r.station};
    endfunction

    function automatic logic [63:0] exception_frame(input logic [7:0] fn,
                                                    input logic [7:0] code);
        return sealed({40'h0, code, fn | mrtu_pkg::EXC_FLAG, station_id}, 3);
    endfunction

    function automatic logic [63:0] read_frame(input logic [15:0] v);
        return sealed({24'h0, v[7:0], v[15:8], mrtu_pkg::READ_BYTES, mrtu_pkg::FUNC_READ,
                       station_id}, 5);
    endfunction

    function automatic logic [63:0] ack_frame(input logic [15:0] a, input logic [15:0] v);
        return sealed({16'h0, v[7:0], v[15:8], a[7:0], a[15:8], mrtu_pkg::FUNC_WRITE,
                       station_id}, 6);
    endfunction

    function automatic logic [63:0] short_frame(input logic [15:0] d);
        logic [15:0] c;
        logic [7:0]  sum;
        c = d;
        if (c <= mrtu_pkg::DIST_MIN) begin
            c = mrtu_pkg::DIST_MIN;
        end else if (c >= mrtu_pkg::DIST_MAX) begin
            c = mrtu_pkg::DIST_MAX;
        end
        sum = mrtu_pkg::SHORT_HEAD + c[15:8] + c[7:0];
        return {32'h0, sum, c[7:0], c[15:8], mrtu_pkg::SHORT_HEAD};
    endfunction

    // works out the response to one request and advances the mirrored state
    function automatic bit predict_response(input mrtu_pkg::req_t r,
                                            output mrtu_pkg::resp_t resp);
        resp = '0;
        if (r.station != station_id && r.station != mrtu_pkg::BROADCAST) begin
            return 1'b0;
        end
        if (modbus_crc(request_bytes(r), 6) != r.crc_word) begin
            return 1'b0;
        end
        if (r.func == mrtu_pkg::FUNC_READ) begin
            if (r.reg_value != 16'd1) begin
                resp.resp_bytes = exception_frame(r.func, mrtu_pkg::EXC_BAD_VALUE);
                resp.resp_len = 4'd5;
            end else if (r.target_reg == cur_saved_addr) begin
                if (cur_short_mode) begin
                    resp.resp_bytes = short_frame(held_dist);
                    resp.resp_len = mrtu_pkg::SHORT_LEN;
                end else begin
                    resp.resp_bytes = read_frame(r.measured_distance);
                    resp.resp_len = 4'd7;
                end
            end else if (r.target_reg == cur_live_addr) begin
                if (r.measure_ok) begin
                    held_dist = r.measured_distance;
                    if (cur_short_mode) begin
                        resp.resp_bytes = short_frame(held_dist);
                        resp.resp_len = mrtu_pkg::SHORT_LEN;
                    end else begin
                        resp.resp_bytes = read_frame(held_dist);
                        resp.resp_len = 4'd7;
                    end
                end else begin
                    resp.resp_bytes = exception_frame(r.func, mrtu_pkg::EXC_BAD_VALUE);
                    resp.resp_len = 4'd5;
                end
            end else begin
                resp.resp_bytes = exception_frame(r.func, mrtu_pkg::EXC_BAD_ADDR);
                resp.resp_len = 4'd5;
            end
            return 1'b1;
        end
        if (r.func == mrtu_pkg::FUNC_WRITE) begin
            if (r.target_reg == cur_baud_addr) begin
                resp.baud_select = (r.reg_value >= 16'd1 && r.reg_value <= mrtu_pkg::BAUD_MAX) ?
                                   r.reg_value[3:0] : 4'd0;
                resp.baud_update = 1'b1;
                resp.resp_bytes = ack_frame(r.target_reg, r.reg_value);
                resp.resp_len = 4'd8;
                return 1'b1;
            end
            if (r.target_reg == cur_stn_addr) begin
                if (r.reg_value == 16'd0 || r.reg_value > mrtu_pkg::STATION_MAX) begin
                    resp.resp_bytes = exception_frame(r.func, mrtu_pkg::EXC_BAD_VALUE);
                    resp.resp_len = 4'd5;
                end else begin
                    resp.resp_bytes = ack_frame(r.target_reg, r.reg_value);
                    resp.resp_len = 4'd8;
                    station_id = r.reg_value[7:0];
                end
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic mrtu_pkg::req_t make_request(input logic [7:0] st,
                                                    input logic [7:0] fn,
                                                    input logic [15:0] ra,
                                                    input logic [15:0] rv,
                                                    input logic [15:0] md, input bit ok);
        mrtu_pkg::req_t r;
        r.station = st;
        r.func = fn;
        r.target_reg = ra;
        r.reg_value = rv;
        r.measured_distance = md;
        r.measure_ok = ok;
        r.crc_word = modbus_crc(request_bytes(r), 6);
        return r;
    endfunction

    function automatic mrtu_pkg::req_t random_request();
        logic [7:0]     st;
        logic [7:0]     fn;
        logic [15:0]    ra;
        logic [15:0]    rv;
        logic [15:0]    md;
        logic [95:0]    raw;
        int             pick;
        mrtu_pkg::req_t r;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            raw = {$urandom, $urandom, $urandom};
            r = raw[mrtu_pkg::IN_BITS-1:0];
            return r;
        end
        pick = $urandom_range(0, 99);
        st = (pick < 65) ? station_id : (pick < 80) ? mrtu_pkg::BROADCAST :
             8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        fn = (pick < 45) ? mrtu_pkg::FUNC_READ : (pick < 88) ? mrtu_pkg::FUNC_WRITE :
             8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0: ra = cur_saved_addr;
            1: ra = cur_live_addr;
            2: ra = cur_baud_addr;
            3: ra = cur_stn_addr;
            default: ra = rand16();
        endcase
        pick = $urandom_range(0, 99);
        if (fn == mrtu_pkg::FUNC_READ) begin
            rv = (pick < 75) ? 16'd1 : (pick < 85) ? 16'($urandom_range(0, 3)) : rand16();
        end else begin
            rv = (pick < 25) ? 16'($urandom_range(0, 15)) :
                 (pick < 75) ? 16'($urandom_range(0, 260)) : rand16();
        end
        pick = $urandom_range(0, 99);
        md = (pick < 20) ? 16'($urandom_range(0, 70)) :
             (pick < 40) ? 16'($urandom_range(1980, 2020)) :
             (pick < 45) ? (pick[0] ? 16'hFFFF : 16'h0000) : rand16();
        r = make_request(st, fn, ra, rv, md, $urandom_range(0, 99) < 85);
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            r.crc_word = r.crc_word ^ (16'h0001 << $urandom_range(0, 15));
        end else if (pick < 10) begin
            r.crc_word = rand16();
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch in %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    // scoreboard: check responses first, then predict the request taken at this edge
    always @(posedge aclk) begin : scoreboard
        mrtu_pkg::resp_t got;
        mrtu_pkg::resp_t want;
        mrtu_pkg::req_t  taken;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[mrtu_pkg::OUT_BITS-1:0];
                responses_seen++;
                if (expected_responses.size() == 0) begin
                    flag_mismatch("unexpected response", got.resp_bytes, 64'h0);
                end else begin
                    want = expected_responses.pop_front();
                    if (got.resp_bytes !== want.resp_bytes) begin
                        flag_mismatch("resp_bytes", got.resp_bytes, want.resp_bytes);
                    end
                    if (got.resp_len !== want.resp_len) begin
                        flag_mismatch("resp_len", 64'(got.resp_len), 64'(want.resp_len));
                    end
                    if (got.baud_select !== want.baud_select) begin
                        flag_mismatch("baud_select", 64'(got.baud_select),
                                      64'(want.baud_select));
                    end
                    if (got.baud_update !== want.baud_update) begin
                        flag_mismatch("baud_update", 64'(got.baud_update),
                                      64'(want.baud_update));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                taken = s_tdata[mrtu_pkg::IN_BITS-1:0];
                requests_sent++;
                if (predict_response(taken, want)) begin
                    expected_responses.push_back(want);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side ready: random stalls and the long hold-off
    initial begin : sink_ready
        forever begin
            @(posedge aclk);
            if (sink_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                sink_hold = 1'b0;
                m_tready <= 1'b1;
            end else if (sink_idling && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_request(input mrtu_pkg::req_t r);
        if (src_idling && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(mrtu_pkg::IN_BYTES*8-mrtu_pkg::IN_BITS){1'b0}}, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_responses.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input mrtu_pkg::cfg_idx_t idx, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic apply_config(input bit short_mode, input logic [15:0] saved,
                                input logic [15:0] live, input logic [15:0] baud,
                                input logic [15:0] stn);
        wait_drained();
        write_reg(mrtu_pkg::CFG_SHORT_MODE, {15'h0, short_mode});
        write_reg(mrtu_pkg::CFG_ADDR_SAVED, saved);
        write_reg(mrtu_pkg::CFG_ADDR_LIVE, live);
        write_reg(mrtu_pkg::CFG_ADDR_BAUD, baud);
        write_reg(mrtu_pkg::CFG_ADDR_STATION, stn);
        cfg_we <= 1'b0;
        cur_short_mode = short_mode;
        cur_saved_addr = saved;
        cur_live_addr = live;
        cur_baud_addr = baud;
        cur_stn_addr = stn;
        settings_applied++;
    endtask

    task automatic run_random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            send_request(random_request());
        end
    endtask

    task automatic test_read_paths();
        send_request(make_request(8'd1, mrtu_pkg::FUNC_READ, SAVED_RESET, 16'd1, 16'h0000,
                                  1'b1));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_READ, SAVED_RESET, 16'd1, 16'hFFFF,
                                  1'b0));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_READ, LIVE_RESET, 16'd1, 16'd1234,
                                  1'b1));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_READ, LIVE_RESET, 16'd1, 16'd999,
                                  1'b0));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_READ, SAVED_RESET, 16'd0, 16'd5,
                                  1'b1));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_READ, SAVED_RESET, 16'hFFFF, 16'd5,
                                  1'b1));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_READ, 16'h0000, 16'd1, 16'd7, 1'b1));
        send_request(make_request(mrtu_pkg::BROADCAST, mrtu_pkg::FUNC_READ, 16'hFFFF, 16'd1,
                                  16'd7, 1'b1));
    endtask

    task automatic test_dropped_frames();
        mrtu_pkg::req_t r;
        send_request(make_request(8'd2, mrtu_pkg::FUNC_READ, SAVED_RESET, 16'd1, 16'd10,
                                  1'b1));
        r = make_request(8'd1, mrtu_pkg::FUNC_READ, LIVE_RESET, 16'd1, 16'd10, 1'b1);
        r.crc_word = r.crc_word ^ 16'h8000;
        send_request(r);
        send_request(make_request(8'd1, 8'h00, SAVED_RESET, 16'd1, 16'd10, 1'b1));
        send_request(make_request(mrtu_pkg::BROADCAST, 8'hFF, SAVED_RESET, 16'd1, 16'd10,
                                  1'b1));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_WRITE, 16'h1234, 16'd5, 16'd10, 1'b1));
    endtask

    task automatic test_write_paths();
        send_request(make_request(8'd1, mrtu_pkg::FUNC_WRITE, BAUD_RESET, 16'd0, 16'd0, 1'b1));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_WRITE, BAUD_RESET, 16'd9, 16'd0, 1'b1));
        send_request(make_request(mrtu_pkg::BROADCAST, mrtu_pkg::FUNC_WRITE, BAUD_RESET,
                                  16'hFFFF, 16'd0, 1'b0));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_WRITE, STN_RESET, 16'd0, 16'd0, 1'b1));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_WRITE, STN_RESET, 16'd248, 16'd0,
                                  1'b1));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_WRITE, STN_RESET, 16'd247, 16'd0,
                                  1'b1));
        send_request(make_request(8'd247, mrtu_pkg::FUNC_READ, LIVE_RESET, 16'd1, 16'd321,
                                  1'b1));
        send_request(make_request(mrtu_pkg::BROADCAST, mrtu_pkg::FUNC_WRITE, STN_RESET, 16'd1,
                                  16'd0, 1'b1));
    endtask

    task automatic test_short_frames();
        apply_config(1'b1, SAVED_RESET, LIVE_RESET, BAUD_RESET, STN_RESET);
        send_request(make_request(8'd1, mrtu_pkg::FUNC_READ, SAVED_RESET, 16'd1, 16'd3000,
                                  1'b1));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_READ, LIVE_RESET, 16'd1, 16'd50, 1'b1));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_READ, LIVE_RESET, 16'd1, 16'd51, 1'b1));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_READ, LIVE_RESET, 16'd1, 16'd2000,
                                  1'b1));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_READ, SAVED_RESET, 16'd1, 16'd0, 1'b0));
    endtask

    task automatic test_address_overlap();
        apply_config(1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_request(make_request(8'd1, mrtu_pkg::FUNC_READ, 16'h0000, 16'd1, 16'd77, 1'b0));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_WRITE, 16'hFFFF, 16'd3, 16'd0, 1'b1));
        apply_config(1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_request(make_request(8'd1, mrtu_pkg::FUNC_READ, 16'hFFFF, 16'd1, 16'd1500, 1'b1));
        send_request(make_request(8'd1, mrtu_pkg::FUNC_WRITE, 16'h0000, 16'd200, 16'd0, 1'b1));
    endtask

    task automatic test_backpressure();
        apply_config(1'b0, SAVED_RESET, LIVE_RESET, BAUD_RESET, STN_RESET);
        src_idling = 1'b0;
        sink_hold = 1'b1;
        run_random_phase(30);
        wait_drained();
    endtask

    task automatic test_random();
        src_idling = 1'b1;
        sink_idling = 1'b1;
        run_random_phase(120);
        apply_config(1'($urandom_range(0, 1)), rand16(), rand16(), rand16(), rand16());
        run_random_phase(120);
        apply_config(1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        run_random_phase(120);
        apply_config(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        run_random_phase(120);
        apply_config(1'b1, rand16(), rand16(), rand16(), rand16());
        run_random_phase(120);
        apply_config(1'b0, SAVED_RESET, LIVE_RESET, BAUD_RESET, STN_RESET);
        src_idling = 1'b0;
        sink_idling = 1'b0;
        run_random_phase(120);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_read_paths();
        test_dropped_frames();
        test_write_paths();
        test_short_frames();
        test_address_overlap();
        test_backpressure();
        test_random();
        wait_drained();
        $display("sent %0d requests under %0d register settings, checked %0d responses",
                 requests_sent, settings_applied, responses_seen);
        $display("covered reads, writes, exceptions, dropped frames and short frames");
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
